// ----- rtl/wtb_pkg.sv -----
package wtb_pkg;

  // Number of 64-bit words the bank can hold.
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned LEN_W  = 9;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LANES  = 8;

  // Commands.
  localparam logic [2:0] OP_BEGIN_FILL      = 3'd0;
  localparam logic [2:0] OP_WRITE           = 3'd1;
  localparam logic [2:0] OP_BEGIN_REPLAY    = 3'd2;
  localparam logic [2:0] OP_READ_WORD       = 3'd3;
  localparam logic [2:0] OP_COMPLETE_REPLAY = 3'd4;
  localparam logic [2:0] OP_RELEASE         = 3'd5;
  localparam logic [2:0] OP_CLEAR           = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_WRONG_STATE   = 3'd1;
  localparam logic [2:0] ST_BAD_DESC      = 3'd2;
  localparam logic [2:0] ST_WRITE_REJ     = 3'd3;
  localparam logic [2:0] ST_LAST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_CTX_MISMATCH  = 3'd5;
  localparam logic [2:0] ST_INDEX_RANGE   = 3'd6;

  // Bank modes.
  localparam logic [1:0] MODE_EMPTY     = 2'd0;
  localparam logic [1:0] MODE_WRITING   = 2'd1;
  localparam logic [1:0] MODE_READY     = 2'd2;
  localparam logic [1:0] MODE_REPLAYING = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [LEN_W-1:0]  tile_length;
    logic [7:0]        lane_mask;
    logic [15:0]       ctx_tag;
    logic [WORD_W-1:0] weight_bytes;
    logic              last_flag;
    logic [7:0]        word_index;
  } wtb_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        read_index;
    logic              read_last;
    logic [7:0]        read_mask;
    logic [15:0]       read_tag;
    logic [WORD_W-1:0] read_weights;
    logic [1:0]        bank_mode;
    logic [31:0]       replays_done;
  } wtb_out_t;

  // Outcome of one command, everything except the stored word.
  typedef struct packed {
    logic [2:0]  status;
    logic        is_read;
    logic [7:0]  read_index;
    logic        read_last;
    logic [7:0]  read_mask;
    logic [15:0] read_tag;
    logic [1:0]  bank_mode;
    logic [31:0] replays_done;
  } wtb_step_t;

  // Word store access for one command.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } wtb_mem_req_t;

endpackage

// ----- rtl/wtb_ctrl.sv -----
// Bank mode and tile descriptor registers, and the decision logic for one command.
module wtb_ctrl
  import wtb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  wtb_in_t      cmd,
  output wtb_step_t    step,
  output wtb_mem_req_t mem_req
);

  logic [1:0]       mode_r, mode_nxt;
  logic [LEN_W-1:0] tile_len_r, tile_len_nxt;
  logic [7:0]       lane_mask_r, lane_mask_nxt;
  logic [15:0]      tag_r, tag_nxt;
  logic [LEN_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [31:0]      replay_cnt_r, replay_cnt_nxt;

  logic [2:0]        status;
  logic              is_read;
  logic              wr;
  logic [LEN_W-1:0]  fill_inc;
  logic              fill_done;
  logic [WORD_W-1:0] keep;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      keep[i*8 +: 8] = {8{lane_mask_r[i]}};
    end
  end

  assign fill_inc  = fill_cnt_r + LEN_W'(1);
  assign fill_done = (fill_inc == tile_len_r);

  always_comb begin
    mode_nxt       = mode_r;
    tile_len_nxt   = tile_len_r;
    lane_mask_nxt  = lane_mask_r;
    tag_nxt        = tag_r;
    fill_cnt_nxt   = fill_cnt_r;
    replay_cnt_nxt = replay_cnt_r;
    status         = ST_OK;
    is_read        = 1'b0;
    wr             = 1'b0;
    unique case (cmd.op)
      OP_BEGIN_FILL: begin
        if (mode_r != MODE_EMPTY) begin
          status = ST_WRONG_STATE;
        end else if (cmd.tile_length == '0 || 32'(cmd.tile_length) > DEPTH ||
                     cmd.lane_mask == '0) begin
          status = ST_BAD_DESC;
        end else begin
          tile_len_nxt  = cmd.tile_length;
          lane_mask_nxt = cmd.lane_mask;
          tag_nxt       = cmd.ctx_tag;
          fill_cnt_nxt  = '0;
          mode_nxt      = MODE_WRITING;
        end
      end
      OP_WRITE: begin
        if (mode_r != MODE_WRITING) begin
          status = ST_WRONG_STATE;
        end else if (cmd.lane_mask != lane_mask_r || fill_cnt_r >= tile_len_r ||
                     32'(fill_cnt_r) >= DEPTH) begin
          status = ST_WRITE_REJ;
        end else begin
          wr           = 1'b1;
          fill_cnt_nxt = fill_inc;
          if (cmd.last_flag != fill_done) begin
            status = ST_LAST_MISMATCH;
          end else if (fill_done) begin
            mode_nxt = MODE_READY;
          end
        end
      end
      OP_BEGIN_REPLAY: begin
        if (mode_r != MODE_READY) begin
          status = ST_WRONG_STATE;
        end else if (cmd.tile_length != tile_len_r || cmd.lane_mask != lane_mask_r ||
                     cmd.ctx_tag != tag_r) begin
          status = ST_CTX_MISMATCH;
        end else begin
          mode_nxt = MODE_REPLAYING;
        end
      end
      OP_READ_WORD: begin
        if (mode_r != MODE_REPLAYING) begin
          status = ST_WRONG_STATE;
        end else if ({1'b0, cmd.word_index} >= tile_len_r ||
                     32'(cmd.word_index) >= DEPTH) begin
          status = ST_INDEX_RANGE;
        end else begin
          is_read = 1'b1;
        end
      end
      OP_COMPLETE_REPLAY: begin
        if (mode_r != MODE_REPLAYING) begin
          status = ST_WRONG_STATE;
        end else begin
          replay_cnt_nxt = replay_cnt_r + 32'd1;
          mode_nxt       = MODE_READY;
        end
      end
      OP_RELEASE: begin
        if (mode_r != MODE_READY) begin
          status = ST_WRONG_STATE;
        end else begin
          mode_nxt      = MODE_EMPTY;
          tile_len_nxt  = '0;
          lane_mask_nxt = '0;
          tag_nxt       = '0;
          fill_cnt_nxt  = '0;
        end
      end
      OP_CLEAR: begin
        mode_nxt       = MODE_EMPTY;
        tile_len_nxt   = '0;
        lane_mask_nxt  = '0;
        tag_nxt        = '0;
        fill_cnt_nxt   = '0;
        replay_cnt_nxt = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_EMPTY;
      tile_len_r   <= '0;
      lane_mask_r  <= '0;
      tag_r        <= '0;
      fill_cnt_r   <= '0;
      replay_cnt_r <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      tile_len_r   <= tile_len_nxt;
      lane_mask_r  <= lane_mask_nxt;
      tag_r        <= tag_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      replay_cnt_r <= replay_cnt_nxt;
    end
  end

  // A read leaves the descriptor unchanged, so the current registers describe the tile.
  always_comb begin
    step.status       = status;
    step.is_read      = is_read;
    step.read_index   = is_read ? cmd.word_index : '0;
    step.read_last    = is_read && (({1'b0, cmd.word_index} + LEN_W'(1)) == tile_len_r);
    step.read_mask    = is_read ? lane_mask_r : '0;
    step.read_tag     = is_read ? tag_r : '0;
    step.bank_mode    = mode_nxt;
    step.replays_done = replay_cnt_nxt;
  end

  always_comb begin
    mem_req.wr_en   = accept && wr;
    mem_req.wr_addr = ADDR_W'(fill_cnt_r);
    mem_req.wr_data = cmd.weight_bytes & keep;
    mem_req.rd_en   = accept && is_read;
    mem_req.rd_addr = ADDR_W'(cmd.word_index);
  end

endmodule

// ----- rtl/weight_tile_bank_top.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | wtb_in_t: command, descriptor, word, index
// out_    | output    | out_valid/out_stall| wtb_out_t: status, read word, mode, count
//
// Every command produces exactly one result transaction, registered in the cycle after it is accepted.
// A command can be accepted in every cycle; the only limit is the single result
// register, so in_stall is high while a result waits and out_stall holds it.
// rst_n is synchronous and active low; it empties the bank and zeroes the replay
// counter. The word store itself is not cleared and needs no clearing pass.
module weight_tile_bank_top
  import wtb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wtb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wtb_out_t out_data
);

  logic         accept;
  wtb_step_t    step;
  wtb_mem_req_t mem_req;

  logic              out_valid_r, out_valid_nxt;
  wtb_step_t         res_r;
  logic [WORD_W-1:0] rdata_r;

  // The word store: one write port for fills, one registered read port for replays.
  // The read data register doubles as the weight field of the result register.
  logic [WORD_W-1:0] mem [DEPTH];

  // A new transaction is taken unless a finished result is still being held.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Mode, descriptor and counters live in the controller; it decides each command
  // in the cycle the command is accepted.
  wtb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (in_data),
    .step    (step),
    .mem_req (mem_req)
  );

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rdata_r <= mem[mem_req.rd_addr];
    end
  end

  // The result register loads on every accepted command and empties once taken.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step;
    end
  end

  assign out_valid = out_valid_r;

  // The read data register holds stale words outside reads, so the weight field
  // is forced to zero unless this result is a successful read.
  always_comb begin
    out_data.status       = res_r.status;
    out_data.read_index   = res_r.read_index;
    out_data.read_last    = res_r.read_last;
    out_data.read_mask    = res_r.read_mask;
    out_data.read_tag     = res_r.read_tag;
    out_data.read_weights = res_r.is_read ? rdata_r : '0;
    out_data.bank_mode    = res_r.bank_mode;
    out_data.replays_done = res_r.replays_done;
  end

endmodule
